[rtl/prot_pkg.sv]
// ----------------------------------------------------------------------------
// prot_pkg: shared types and constants of the point rotator
// Payload structs, fixed-point constants and the arctangent table of the
// rotation-mode CORDIC chain.
// ----------------------------------------------------------------------------
package prot_pkg;

	// field widths
	localparam int ANGLE_W    = 26;
	localparam int COORD_IN_W = 32;
	localparam int OUT_W      = 24;

	// CORDIC vector and angle widths, Q30
	localparam int ROT_W     = 32;
	localparam int PROD_W    = 54;
	localparam int RAD_SHIFT = 18;
	localparam int ZW        = PROD_W - RAD_SHIFT;

	// coordinate Q16 times trig Q30
	localparam int FRAC_W = 46;

	// register port
	localparam int DATA_W      = 32;
	localparam int PADDR_W     = 3;
	localparam int REG_IDX_LSB = 2;
	localparam logic [0:0] REG_ANGLE = 1'b0;

	// degrees to radians with pi = 3.1415, Q0.32
	localparam logic signed [27:0] DEG_TO_RAD_Q32 = 28'sd74959110;
	localparam logic signed [PROD_W-1:0] ROUND_Q48 = PROD_W'(64'sd131072);

	localparam logic signed [ZW-1:0] PI_Z      = 36'sd3373259426;
	localparam logic signed [ZW-1:0] TWO_PI_Z  = 36'sd6746518852;
	localparam logic signed [ZW-1:0] HALF_PI_Z = 36'sd1686629713;
	localparam logic signed [ROT_W-1:0] HALF_PI_R = 32'sd1686629713;

	localparam logic signed [ROT_W-1:0] GAIN_Q30 = 32'sd652032874;

	localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sd8388607;
	localparam logic signed [OUT_W-1:0] OUT_MIN = -24'sd8388608;

	typedef struct packed {
		logic signed [COORD_IN_W-1:0] x_coord;
		logic signed [COORD_IN_W-1:0] y_coord;
	} point_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] x_hundredths;
		logic signed [OUT_W-1:0] y_hundredths;
	} result_t;

	// CORDIC state handed from cell to cell
	typedef struct packed {
		logic                    flip;
		logic signed [ROT_W-1:0] cx;
		logic signed [ROT_W-1:0] cy;
		logic signed [ROT_W-1:0] z;
	} rot_t;

	// atan(2^-k) in Q30, truncated
	function automatic logic signed [ROT_W-1:0] atan_q30(input logic [4:0] k);
		logic signed [ROT_W-1:0] a;
		case (k)
			5'd0:  a = 32'sh3243F6A8;
			5'd1:  a = 32'sh1DAC6705;
			5'd2:  a = 32'sh0FADBAFC;
			5'd3:  a = 32'sh07F56EA6;
			5'd4:  a = 32'sh03FEAB76;
			5'd5:  a = 32'sh01FFD55B;
			5'd6:  a = 32'sh00FFFAAA;
			5'd7:  a = 32'sh007FFF55;
			5'd8:  a = 32'sh003FFFEA;
			5'd9:  a = 32'sh001FFFFD;
			5'd10: a = 32'sh000FFFFF;
			5'd11: a = 32'sh0007FFFF;
			5'd12: a = 32'sh0003FFFF;
			5'd13: a = 32'sh0001FFFF;
			5'd14: a = 32'sh0000FFFF;
			5'd15: a = 32'sh00007FFF;
			5'd16: a = 32'sh00003FFF;
			5'd17: a = 32'sh00001FFF;
			5'd18: a = 32'sh00000FFF;
			5'd19: a = 32'sh000007FF;
			5'd20: a = 32'sh000003FF;
			5'd21: a = 32'sh000001FF;
			5'd22: a = 32'sh000000FF;
			5'd23: a = 32'sh0000007F;
			5'd24: a = 32'sh0000003F;
			5'd25: a = 32'sh0000001F;
			5'd26: a = 32'sh0000000F;
			5'd27: a = 32'sh00000008;
			5'd28: a = 32'sh00000004;
			5'd29: a = 32'sh00000002;
			5'd30: a = 32'sh00000001;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

[rtl/prot_angle_prep.sv]
// ----------------------------------------------------------------------------
// prot_angle_prep: angle conversion and quadrant folding
// Converts the degree register to a Q30 radian angle, folds it into
// [-pi/2, pi/2] and seeds the CORDIC vector, four stages deep.
// ----------------------------------------------------------------------------
module prot_angle_prep import prot_pkg::*; #(
	parameter int CW = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic signed [ANGLE_W-1:0]  angle_deg,
	input  logic                       up_valid,
	output logic                       up_ready,
	input  logic signed [CW-1:0]       up_px,
	input  logic signed [CW-1:0]       up_py,
	output logic                       dn_valid,
	input  logic                       dn_ready,
	output rot_t                       dn_rot,
	output logic signed [CW-1:0]       dn_px,
	output logic signed [CW-1:0]       dn_py
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic signed [PROD_W-1:0] prod, prod_s1, rnd;
	logic signed [ZW-1:0]     z_s2, z3_next, z_s3, z4;
	logic                     flip4;
	rot_t                     rot_next, rot_s4;

	logic signed [CW-1:0] px_s1, py_s1, px_s2, py_s2, px_s3, py_s3, px_s4, py_s4;

	assign prod = PROD_W'(angle_deg) * PROD_W'(DEG_TO_RAD_Q32);
	assign rnd  = prod_s1 + ROUND_Q48;

	// one wrap by a full turn
	always_comb begin
		if (z_s2 > PI_Z) begin
			z3_next = z_s2 - TWO_PI_Z;
		end else if (z_s2 < -PI_Z) begin
			z3_next = z_s2 + TWO_PI_Z;
		end else begin
			z3_next = z_s2;
		end
	end

	// half turn folds negate cos and sin later
	always_comb begin
		flip4 = 1'b0;
		z4    = z_s3;
		if (z_s3 > HALF_PI_Z) begin
			z4    = z_s3 - PI_Z;
			flip4 = 1'b1;
		end else if (z_s3 < -HALF_PI_Z) begin
			z4    = z_s3 + PI_Z;
			flip4 = 1'b1;
		end
		rot_next.flip = flip4;
		rot_next.cx   = GAIN_Q30;
		rot_next.cy   = '0;
		rot_next.z    = z4[ROT_W-1:0];
	end

	assign rdy_s4   = !v_s4 || dn_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= up_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			prod_s1 <= prod;
			px_s1   <= up_px;
			py_s1   <= up_py;
		end
		if (rdy_s2 && v_s1) begin
			z_s2  <= rnd[PROD_W-1:RAD_SHIFT];
			px_s2 <= px_s1;
			py_s2 <= py_s1;
		end
		if (rdy_s3 && v_s2) begin
			z_s3  <= z3_next;
			px_s3 <= px_s2;
			py_s3 <= py_s2;
		end
		if (rdy_s4 && v_s3) begin
			rot_s4 <= rot_next;
			px_s4  <= px_s3;
			py_s4  <= py_s3;
		end
	end

	assign dn_valid = v_s4;
	assign dn_rot   = rot_s4;
	assign dn_px    = px_s4;
	assign dn_py    = py_s4;

`ifndef SYNTHESIS
	a_turn_fold: assert property (@(posedge clk) disable iff (!arst_n)
		rdy_s3 && v_s2 |=> v_s3 && (z_s3 <= PI_Z) && (z_s3 >= -PI_Z))
		else $error("angle not folded into one turn");

	a_half_fold: assert property (@(posedge clk) disable iff (!arst_n)
		rdy_s4 && v_s3 |=> v_s4 && (rot_s4.z <= HALF_PI_R) && (rot_s4.z >= -HALF_PI_R)
			&& (rot_s4.cx == GAIN_Q30) && (rot_s4.cy == '0))
		else $error("cordic seed out of the right half plane");
`endif

endmodule

[rtl/prot_cordic_cell.sv]
// ----------------------------------------------------------------------------
// prot_cordic_cell: one rotation-mode CORDIC micro-rotation
// Holds one vector and its point, rotates it by +-atan(2^-k) and hands it
// to the next cell; the shift k is fixed per cell.
// ----------------------------------------------------------------------------
module prot_cordic_cell import prot_pkg::*; #(
	parameter int CW    = 32,
	parameter int STAGE = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_ready,
	input  rot_t                 up_rot,
	input  logic signed [CW-1:0] up_px,
	input  logic signed [CW-1:0] up_py,
	output logic                 dn_valid,
	input  logic                 dn_ready,
	output rot_t                 dn_rot,
	output logic signed [CW-1:0] dn_px,
	output logic signed [CW-1:0] dn_py
);

	// only the low five bits of the stage index count
	localparam logic [4:0] SHIFT = 5'(STAGE);

	logic                    valid_q;
	rot_t                    rot_q, rot_next;
	logic signed [CW-1:0]    px_q, py_q;
	logic signed [ROT_W-1:0] dx, dy, da;

	assign dx = up_rot.cy >>> SHIFT;
	assign dy = up_rot.cx >>> SHIFT;
	assign da = atan_q30(SHIFT);

	// zero residual counts as positive
	always_comb begin
		rot_next.flip = up_rot.flip;
		if (!up_rot.z[ROT_W-1]) begin
			rot_next.cx = up_rot.cx - dx;
			rot_next.cy = up_rot.cy + dy;
			rot_next.z  = up_rot.z - da;
		end else begin
			rot_next.cx = up_rot.cx + dx;
			rot_next.cy = up_rot.cy - dy;
			rot_next.z  = up_rot.z + da;
		end
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			rot_q <= rot_next;
			px_q  <= up_px;
			py_q  <= up_py;
		end
	end

	assign dn_valid = valid_q;
	assign dn_rot   = rot_q;
	assign dn_px    = px_q;
	assign dn_py    = py_q;

`ifndef SYNTHESIS
	a_cell_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !dn_ready |=> valid_q && $stable(rot_q) && $stable(px_q) && $stable(py_q))
		else $error("cordic cell lost its vector while stalled");
`endif

endmodule

[rtl/prot_combine.sv]
// ----------------------------------------------------------------------------
// prot_combine: rotation products and rounding to hundredths
// Forms x*cos - y*sin and x*sin + y*cos from split partial products, scales
// by 100 and rounds half away from zero with saturation, five stages deep.
// ----------------------------------------------------------------------------
module prot_combine import prot_pkg::*; #(
	parameter int CW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_ready,
	input  rot_t                 up_rot,
	input  logic signed [CW-1:0] up_px,
	input  logic signed [CW-1:0] up_py,
	output logic                 dn_valid,
	input  logic                 dn_ready,
	output result_t              dn_res
);

	localparam int LW  = CW / 2;
	localparam int HW  = CW - LW;
	localparam int HPW = HW + ROT_W;
	localparam int LPW = LW + 1 + ROT_W;
	localparam int HSW = HPW + 1;
	localparam int LSW = LPW + 1;
	localparam int VW  = CW + ROT_W + 1;
	localparam int TW  = VW + 7;
	localparam int FW0 = TW - FRAC_W;
	localparam int SW  = (FW0 + 1 > OUT_W) ? FW0 + 1 : OUT_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	logic signed [HW-1:0] ph_x, ph_y;
	logic signed [LW:0]   pl_x, pl_y;

	logic signed [HPW-1:0] xh_c_s1, xh_s_s1, yh_c_s1, yh_s_s1;
	logic signed [LPW-1:0] xl_c_s1, xl_s_s1, yl_c_s1, yl_s_s1;
	logic                  flip_s1;

	logic signed [HSW-1:0] hx, hy, hx_s2, hy_s2;
	logic signed [LSW-1:0] lx, ly, lx_s2, ly_s2;
	logic signed [VW-1:0]  vx_s3, vy_s3;
	logic signed [TW-1:0]  tx_s4, ty_s4;
	result_t               res_s5;

	// scaled value in Q46 to hundredths, halves away from zero
	function automatic logic signed [OUT_W-1:0] to_out(input logic signed [TW-1:0] t);
		logic                 inc;
		logic signed [SW-1:0] f;
		inc = t[TW-1] ? (t[FRAC_W-1] && (|t[FRAC_W-2:0])) : t[FRAC_W-1];
		f   = SW'($signed(t[TW-1:FRAC_W])) + SW'(inc);
		if (f > SW'(OUT_MAX)) begin
			return OUT_MAX;
		end else if (f < SW'(OUT_MIN)) begin
			return OUT_MIN;
		end
		return f[OUT_W-1:0];
	endfunction

	// split each coordinate into a signed high half and an unsigned low half
	assign ph_x = up_px[CW-1:LW];
	assign ph_y = up_py[CW-1:LW];
	assign pl_x = $signed({1'b0, up_px[LW-1:0]});
	assign pl_y = $signed({1'b0, up_py[LW-1:0]});

	// a half-turn fold negates both cos and sin, so both sums flip sign
	always_comb begin
		if (!flip_s1) begin
			hx = HSW'(xh_c_s1) - HSW'(yh_s_s1);
			hy = HSW'(xh_s_s1) + HSW'(yh_c_s1);
			lx = LSW'(xl_c_s1) - LSW'(yl_s_s1);
			ly = LSW'(xl_s_s1) + LSW'(yl_c_s1);
		end else begin
			hx = HSW'(yh_s_s1) - HSW'(xh_c_s1);
			hy = -HSW'(xh_s_s1) - HSW'(yh_c_s1);
			lx = LSW'(yl_s_s1) - LSW'(xl_c_s1);
			ly = -LSW'(xl_s_s1) - LSW'(yl_c_s1);
		end
	end

	assign rdy_s5   = !v_s5 || dn_ready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= up_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
			if (rdy_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			xh_c_s1 <= HPW'(ph_x) * HPW'(up_rot.cx);
			xh_s_s1 <= HPW'(ph_x) * HPW'(up_rot.cy);
			yh_c_s1 <= HPW'(ph_y) * HPW'(up_rot.cx);
			yh_s_s1 <= HPW'(ph_y) * HPW'(up_rot.cy);
			xl_c_s1 <= LPW'(pl_x) * LPW'(up_rot.cx);
			xl_s_s1 <= LPW'(pl_x) * LPW'(up_rot.cy);
			yl_c_s1 <= LPW'(pl_y) * LPW'(up_rot.cx);
			yl_s_s1 <= LPW'(pl_y) * LPW'(up_rot.cy);
			flip_s1 <= up_rot.flip;
		end
		if (rdy_s2 && v_s1) begin
			hx_s2 <= hx;
			hy_s2 <= hy;
			lx_s2 <= lx;
			ly_s2 <= ly;
		end
		if (rdy_s3 && v_s2) begin
			vx_s3 <= (VW'(hx_s2) <<< LW) + VW'(lx_s2);
			vy_s3 <= (VW'(hy_s2) <<< LW) + VW'(ly_s2);
		end
		// times 100 as 64 + 32 + 4
		if (rdy_s4 && v_s3) begin
			tx_s4 <= (TW'(vx_s3) <<< 6) + (TW'(vx_s3) <<< 5) + (TW'(vx_s3) <<< 2);
			ty_s4 <= (TW'(vy_s3) <<< 6) + (TW'(vy_s3) <<< 5) + (TW'(vy_s3) <<< 2);
		end
		if (rdy_s5 && v_s4) begin
			res_s5.x_hundredths <= to_out(tx_s4);
			res_s5.y_hundredths <= to_out(ty_s4);
		end
	end

	assign dn_valid = v_s5;
	assign dn_res   = res_s5;

endmodule

[rtl/point_rotator.sv]
// ----------------------------------------------------------------------------
// point_rotator: rotates each point about the origin by the programmed angle
// A point passes the angle preparation stages, the CORDIC_STAGES cells and
// the combine stages in turn. It takes one point per cycle when the output
// side does not stall, through a chain of per-stage registers, each stage
// with its own valid bit; an empty stage always takes new data.
// Reset clears all valid bits and sets the angle register to zero.
// ----------------------------------------------------------------------------
module point_rotator import prot_pkg::*; #(
	parameter int COORD_WIDTH   = 32,
	parameter int CORDIC_STAGES = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               pt_valid,
	output logic               pt_ready,
	input  point_t             pt_data,
	output logic               res_valid,
	input  logic               res_ready,
	output result_t            res_data
);

	localparam int N = CORDIC_STAGES;

	logic signed [ANGLE_W-1:0]     angle_q;
	logic                          cfg_wr;
	logic signed [COORD_WIDTH-1:0] px_in, py_in;

	logic                          ch_valid [0:N];
	logic                          ch_ready [0:N];
	rot_t                          ch_rot   [0:N];
	logic signed [COORD_WIDTH-1:0] ch_px    [0:N];
	logic signed [COORD_WIDTH-1:0] ch_py    [0:N];

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite
		&& (paddr[PADDR_W-1:REG_IDX_LSB] == REG_ANGLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
		end else if (cfg_wr) begin
			angle_q <= pwdata[ANGLE_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[PADDR_W-1:REG_IDX_LSB])
			REG_ANGLE: prdata = DATA_W'(angle_q);
			default:   prdata = '0;
		endcase
	end

	// coordinate taken from its low bits as two's complement
	assign px_in = COORD_WIDTH'($unsigned(pt_data.x_coord));
	assign py_in = COORD_WIDTH'($unsigned(pt_data.y_coord));

	prot_angle_prep #(
		.CW(COORD_WIDTH)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.angle_deg(angle_q),
		.up_valid (pt_valid),
		.up_ready (pt_ready),
		.up_px    (px_in),
		.up_py    (py_in),
		.dn_valid (ch_valid[0]),
		.dn_ready (ch_ready[0]),
		.dn_rot   (ch_rot[0]),
		.dn_px    (ch_px[0]),
		.dn_py    (ch_py[0])
	);

	for (genvar i = 0; i < N; i++) begin : g_cell
		prot_cordic_cell #(
			.CW   (COORD_WIDTH),
			.STAGE(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_valid(ch_valid[i]),
			.up_ready(ch_ready[i]),
			.up_rot  (ch_rot[i]),
			.up_px   (ch_px[i]),
			.up_py   (ch_py[i]),
			.dn_valid(ch_valid[i+1]),
			.dn_ready(ch_ready[i+1]),
			.dn_rot  (ch_rot[i+1]),
			.dn_px   (ch_px[i+1]),
			.dn_py   (ch_py[i+1])
		);
	end

	prot_combine #(
		.CW(COORD_WIDTH)
	) u_combine (
		.clk     (clk),
		.arst_n  (arst_n),
		.up_valid(ch_valid[N]),
		.up_ready(ch_ready[N]),
		.up_rot  (ch_rot[N]),
		.up_px   (ch_px[N]),
		.up_py   (ch_py[N]),
		.dn_valid(res_valid),
		.dn_ready(res_ready),
		.dn_res  (res_data)
	);

endmodule
